// ===== src/touch_packet_reformatter_defines.svh =====
// Assertion macros used by the touch packet reformatter top level.
`ifndef TOUCH_PACKET_REFORMATTER_DEFINES_SVH
`define TOUCH_PACKET_REFORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TPR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpr assertion failed");

`else

`define TPR_ASSERT_IMP(label, ante, cons)
`define TPR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/tpr_pkg.sv =====
// Types, constants and helper functions of the touch packet reformatter.
`default_nettype none

package tpr_pkg;

   // Sizes of the controller packet and the host packet.
   localparam int PACKET_LEN_DEF = 6;
   localparam int HOST_LEN       = 6;
   localparam int BYTE_W         = 8;
   localparam int HALF_W         = 6;
   localparam int COORD_W        = 12;
   localparam int SCALE_W        = 16;
   localparam int PROD_W         = COORD_W + SCALE_W;
   localparam int FRAC_W         = 14;
   localparam int SAT_W          = 16;
   localparam int OUT_SHIFT      = 4;
   localparam int QUEUE_DEPTH    = 2;

   // Positions of the fields inside a controller packet.
   localparam int IDX_X_HI  = 0;
   localparam int IDX_X_LO  = 1;
   localparam int IDX_Y_HI  = 2;
   localparam int IDX_Y_LO  = 3;
   localparam int IDX_TOUCH = 5;

   // Marker bits and fixed values.
   localparam logic [1:0]         START_CODE  = 2'b11;
   localparam logic [COORD_W-1:0] FLIP_VAL    = 12'd4095;
   localparam logic [SAT_W-1:0]   SAT_MAX     = 16'hFFFF;
   localparam logic [BYTE_W-1:0]  HDR_X_HI    = 8'hC0;
   localparam logic [BYTE_W-1:0]  HDR_X_LO    = 8'h80;
   localparam logic [BYTE_W-1:0]  HDR_Y_HI    = 8'h40;
   localparam logic [BYTE_W-1:0]  TOUCH_TAIL  = 8'h0F;
   localparam logic [BYTE_W-1:0]  ZERO_BYTE   = 8'h00;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

   // Configuration register indexes.
   localparam int               CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE = 2'd1;

   // One complete controller packet, as the back end needs it.
   typedef struct packed {
      logic               touch;
      logic [COORD_W-1:0] y_raw;
      logic [COORD_W-1:0] x_raw;
   } pkt_rec_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   // Product of a flipped coordinate and a Q2.14 scale down to the host byte.
   function automatic logic [BYTE_W-1:0] scale_byte(input logic [PROD_W-1:0] prod);
      logic [SAT_W-1:0] whole;
      whole = SAT_W'(prod >> FRAC_W);
      if (whole > SAT_MAX) begin
         whole = SAT_MAX;
      end
      return whole[OUT_SHIFT +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

// ===== src/tpr_front.sv =====
// Front end: hunts for the start byte and collects one controller packet.
`default_nettype none

module tpr_front #(
   parameter int PACKET_LEN = tpr_pkg::PACKET_LEN_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [tpr_pkg::BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   input  wire tpr_pkg::q_stat_type       q_stat,
   output logic                           q_push,
   output tpr_pkg::pkt_rec_type           q_rec
);

   localparam int FILL_W = $clog2(PACKET_LEN);

   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [tpr_pkg::HALF_W-1:0] x_hi_ff, x_hi_in;
   logic [tpr_pkg::HALF_W-1:0] x_lo_ff, x_lo_in;
   logic [tpr_pkg::HALF_W-1:0] y_hi_ff, y_hi_in;
   logic [tpr_pkg::HALF_W-1:0] y_lo_ff, y_lo_in;
   logic                       touch_ff, touch_in;
   logic                       take;
   logic                       active;
   logic                       at_end;

   // A transfer is taken whenever the queue can hold a finished packet.
   assign req_tready = !q_stat.full;
   assign take       = req_tvalid && req_tready;

   // A packet is in progress once the fill count has left zero, or when a start byte arrives.
   assign active = (fill_ff != '0) ||
                   (req_tdata[tpr_pkg::BYTE_W-1 -: 2] == tpr_pkg::START_CODE);
   assign at_end = (fill_ff == FILL_W'(PACKET_LEN - 1));

   // Fill count and field capture.
   always_comb begin
      fill_in  = fill_ff;
      x_hi_in  = x_hi_ff;
      x_lo_in  = x_lo_ff;
      y_hi_in  = y_hi_ff;
      y_lo_in  = y_lo_ff;
      touch_in = touch_ff;
      if (take && active) begin
         fill_in = at_end ? '0 : fill_ff + FILL_W'(1);
         if (fill_ff == FILL_W'(tpr_pkg::IDX_X_HI)) begin
            x_hi_in = req_tdata[tpr_pkg::HALF_W-1:0];
         end
         if (fill_ff == FILL_W'(tpr_pkg::IDX_X_LO)) begin
            x_lo_in = req_tdata[tpr_pkg::HALF_W-1:0];
         end
         if (fill_ff == FILL_W'(tpr_pkg::IDX_Y_HI)) begin
            y_hi_in = req_tdata[tpr_pkg::HALF_W-1:0];
         end
         if (fill_ff == FILL_W'(tpr_pkg::IDX_Y_LO)) begin
            y_lo_in = req_tdata[tpr_pkg::HALF_W-1:0];
         end
         if (fill_ff == FILL_W'(tpr_pkg::IDX_TOUCH)) begin
            touch_in = (req_tdata != '0);
         end
      end
   end

   // The finished packet goes to the queue on its last byte.
   assign q_push      = take && active && at_end;
   assign q_rec.x_raw = {x_hi_ff, x_lo_ff};
   assign q_rec.y_raw = {y_hi_ff, y_lo_ff};
   assign q_rec.touch = touch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      x_hi_ff  <= x_hi_in;
      x_lo_ff  <= x_lo_in;
      y_hi_ff  <= y_hi_in;
      y_lo_ff  <= y_lo_in;
      touch_ff <= touch_in;
   end

endmodule

`default_nettype wire

// ===== src/tpr_queue.sv =====
// Short queue of complete controller packets between front and back ends.
`default_nettype none

module tpr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tpr_pkg::pkt_rec_type wr_rec,
   input  wire logic                 pop,
   output tpr_pkg::pkt_rec_type      rd_rec,
   output tpr_pkg::q_stat_type       stat
);

   localparam int PTR_W = $clog2(tpr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tpr_pkg::QUEUE_DEPTH + 1);

   tpr_pkg::pkt_rec_type q_mem [tpr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == CNT_W'(tpr_pkg::QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign rd_rec     = q_mem[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tpr_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tpr_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= wr_rec;
      end
   end

endmodule

`default_nettype wire

// ===== src/tpr_back.sv =====
// Back end: flips and scales the coordinates and sends the six host bytes.
`default_nettype none

module tpr_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tpr_pkg::q_stat_type         q_stat,
   input  wire tpr_pkg::pkt_rec_type        q_rec,
   output logic                             q_pop,
   input  wire logic [tpr_pkg::SCALE_W-1:0] x_scale,
   input  wire logic [tpr_pkg::SCALE_W-1:0] y_scale,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [tpr_pkg::BYTE_W-1:0]       rsp_tdata,   // [7:0] tx_byte
   output logic                             rsp_tlast
);

   localparam int CNT_W = $clog2(tpr_pkg::HOST_LEN);

   logic                        mul_valid_ff, mul_valid_in;
   logic [tpr_pkg::PROD_W-1:0]  x_prod_ff, x_prod_in;
   logic [tpr_pkg::PROD_W-1:0]  y_prod_ff, y_prod_in;
   logic                        touch_ff;
   logic                        snd_valid_ff, snd_valid_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tpr_pkg::BYTE_W-1:0]  snd_bytes_ff [tpr_pkg::HOST_LEN];
   logic [tpr_pkg::BYTE_W-1:0]  snd_bytes_in [tpr_pkg::HOST_LEN];
   logic [tpr_pkg::BYTE_W-1:0]  x_byte;
   logic [tpr_pkg::BYTE_W-1:0]  y_byte;
   logic [tpr_pkg::COORD_W-1:0] x_flip;
   logic [tpr_pkg::COORD_W-1:0] y_flip;
   logic                        snd_fire;
   logic                        snd_done;
   logic                        snd_load;

   // Handshake between the multiply stage and the send stage.
   assign snd_fire = snd_valid_ff && rsp_tready;
   assign snd_done = snd_fire && (cnt_ff == CNT_W'(tpr_pkg::HOST_LEN - 1));
   assign snd_load = mul_valid_ff && (!snd_valid_ff || snd_done);
   assign q_pop    = q_stat.valid && (!mul_valid_ff || snd_load);

   // Multiply stage: flip each coordinate and apply its scale.
   assign x_flip    = tpr_pkg::FLIP_VAL - q_rec.x_raw;
   assign y_flip    = tpr_pkg::FLIP_VAL - q_rec.y_raw;
   assign x_prod_in = tpr_pkg::PROD_W'(x_flip) * tpr_pkg::PROD_W'(x_scale);
   assign y_prod_in = tpr_pkg::PROD_W'(y_flip) * tpr_pkg::PROD_W'(y_scale);
   assign mul_valid_in = q_pop || (mul_valid_ff && !snd_load);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_prod_ff <= x_prod_in;
         y_prod_ff <= y_prod_in;
         touch_ff  <= q_rec.touch;
      end
   end

   // Host packet assembly and output shift line.
   assign x_byte = tpr_pkg::scale_byte(x_prod_ff);
   assign y_byte = tpr_pkg::scale_byte(y_prod_ff);

   always_comb begin
      for (int i = 0; i < tpr_pkg::HOST_LEN; i++) begin
         snd_bytes_in[i] = snd_bytes_ff[i];
      end
      if (snd_load) begin
         if (touch_ff) begin
            snd_bytes_in[0] = tpr_pkg::HDR_X_HI | {6'b0, x_byte[7:6]};
            snd_bytes_in[1] = tpr_pkg::HDR_X_LO | {2'b0, x_byte[5:0]};
            snd_bytes_in[2] = tpr_pkg::HDR_Y_HI | {6'b0, y_byte[7:6]};
            snd_bytes_in[3] = {2'b0, y_byte[5:0]};
            snd_bytes_in[4] = tpr_pkg::ZERO_BYTE;
            snd_bytes_in[5] = tpr_pkg::TOUCH_TAIL;
         end else begin
            snd_bytes_in[0] = tpr_pkg::HDR_X_HI;
            snd_bytes_in[1] = tpr_pkg::HDR_X_LO;
            snd_bytes_in[2] = tpr_pkg::HDR_Y_HI;
            snd_bytes_in[3] = tpr_pkg::ZERO_BYTE;
            snd_bytes_in[4] = tpr_pkg::ZERO_BYTE;
            snd_bytes_in[5] = tpr_pkg::ZERO_BYTE;
         end
      end else if (snd_fire) begin
         for (int i = 0; i < tpr_pkg::HOST_LEN - 1; i++) begin
            snd_bytes_in[i] = snd_bytes_ff[i + 1];
         end
      end
   end

   // Byte counter of the packet being sent.
   always_comb begin
      snd_valid_in = snd_valid_ff;
      cnt_in       = cnt_ff;
      if (snd_load) begin
         snd_valid_in = 1'b1;
         cnt_in       = '0;
      end else if (snd_done) begin
         snd_valid_in = 1'b0;
         cnt_in       = '0;
      end else if (snd_fire) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         snd_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         snd_valid_ff <= snd_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < tpr_pkg::HOST_LEN; i++) begin
         snd_bytes_ff[i] <= snd_bytes_in[i];
      end
   end

   assign rsp_tvalid = snd_valid_ff;
   assign rsp_tdata  = snd_bytes_ff[0];
   assign rsp_tlast  = (cnt_ff == CNT_W'(tpr_pkg::HOST_LEN - 1));

endmodule

`default_nettype wire

// ===== src/touch_packet_reformatter.sv =====
// rsp_tvalid follows the last controller byte through the queue, multiply and send registers.
// One controller byte per cycle in while the queue is not full; one host byte per cycle out
// while rsp_tready is high; a packet is PACKET_LEN bytes in and six bytes out.
// A two-entry packet queue lets input continue while the six-byte send is stalled.
// Reset (synchronous, active high) clears collection, the queue, the send stage
// and sets both scales to 1.0.
`default_nettype none
`include "touch_packet_reformatter_defines.svh"

module touch_packet_reformatter #(
   parameter int PACKET_LEN = tpr_pkg::PACKET_LEN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tpr_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [tpr_pkg::BYTE_W-1:0]         rsp_tdata,   // [7:0] tx_byte
   output logic                               rsp_tlast,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tpr_pkg::SCALE_W-1:0]   csr_data
);

   logic [tpr_pkg::SCALE_W-1:0] x_scale_ff;
   logic [tpr_pkg::SCALE_W-1:0] y_scale_ff;
   tpr_pkg::q_stat_type         q_stat;
   tpr_pkg::pkt_rec_type        push_rec;
   tpr_pkg::pkt_rec_type        pop_rec;
   logic                        q_push;
   logic                        q_pop;

   // Scale registers; writes must arrive only while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= tpr_pkg::SCALE_RESET;
         y_scale_ff <= tpr_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tpr_pkg::CSR_X_SCALE) begin
            x_scale_ff <= csr_data;
         end
         if (csr_index == tpr_pkg::CSR_Y_SCALE) begin
            y_scale_ff <= csr_data;
         end
      end
   end

   tpr_front #(
      .PACKET_LEN (PACKET_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_rec      (push_rec)
   );

   tpr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_rec (push_rec),
      .pop    (q_pop),
      .rd_rec (pop_rec),
      .stat   (q_stat)
   );

   tpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_rec      (pop_rec),
      .q_pop      (q_pop),
      .x_scale    (x_scale_ff),
      .y_scale    (y_scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A finished packet never arrives at a full queue.
   `TPR_ASSERT_IMP(a_queue_no_overflow, q_push, !q_stat.full)

   // The last host byte is the touch tail or the untouch zero.
   `TPR_ASSERT_IMP(a_last_byte_code, rsp_tvalid && rsp_tlast,
                   rsp_tdata == tpr_pkg::TOUCH_TAIL || rsp_tdata == tpr_pkg::ZERO_BYTE)

   // A packet seen by the back end while its multiply stage is free is taken at once.
   `TPR_ASSERT_IMP(a_back_takes_packet, q_stat.valid && !u_back.mul_valid_ff, q_pop)

endmodule

`default_nettype wire
